/* hdl/bspp_pkg.sv */
// ----------------------------------------------------------------------------
// bspp_pkg: shared types and constants of the boot sector partition parser
// Sector layout offsets, signature bytes, OEM name table and result types.
// ----------------------------------------------------------------------------
package bspp_pkg;

    localparam int MAX_PARTITIONS_DEFAULT = 4;
    localparam int QUEUE_DEPTH_DEFAULT    = 2;
    localparam int TABLE_ENTRIES          = 4;

    localparam logic [8:0] TABLE_BASE = 9'd446;
    localparam logic [8:0] TABLE_END  = 9'd510;
    localparam logic [8:0] SIG_FIRST  = 9'd510;
    localparam logic [8:0] SIG_SECOND = 9'd511;

    localparam logic [7:0] MARK_FIRST  = 8'h55;
    localparam logic [7:0] MARK_SECOND = 8'hAA;
    localparam logic [7:0] GPT_TYPE    = 8'hEE;

    localparam logic [3:0] FIELD_TYPE = 4'd4;
    localparam logic [1:0] LANE_START = 2'd2;
    localparam logic [1:0] LANE_COUNT = 2'd3;

    localparam int NAME_COUNT = 5;
    localparam int NAME_LEN   = 8;

    localparam logic [0:NAME_COUNT-1][63:0] NAME_TEXT = '{
        "EXFAT   ",
        "NTFS    ",
        "FAT32   ",
        "FAT16   ",
        "FAT12   "
    };

    localparam logic [0:NAME_COUNT-1][8:0] NAME_BASE = '{
        9'd3, 9'd3, 9'd82, 9'd54, 9'd54
    };

    localparam logic [2:0] FS_UNKNOWN = 3'd0;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] start;
        logic [7:0]  ptype;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  entry_index;
        logic [7:0]  part_type;
        logic [31:0] start_lba;
        logic [31:0] sector_count;
        logic        signature_ok;
        logic [2:0]  fs_kind;
        logic        protective_gpt;
        logic [2:0]  partition_count;
        logic        last;
    } result_t;

    function automatic logic [7:0] name_char(input int k, input logic [2:0] i);
        logic [5:0] sh;
        sh = 6'(7 - int'(i)) << 3;
        return 8'(NAME_TEXT[k] >> sh);
    endfunction

endpackage

/* hdl/bspp_front.sv */
// ----------------------------------------------------------------------------
// bspp_front: byte intake and classification
// Tracks the sector offset, OEM name matches, partition table entries and the
// signature, and pushes one sector job into the queue as it accepts byte 511.
// ----------------------------------------------------------------------------
module bspp_front #(
    parameter int MAX_PARTITIONS = bspp_pkg::MAX_PARTITIONS_DEFAULT,
    parameter int JOB_W          = 4 + MAX_PARTITIONS * bspp_pkg::ENTRY_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             sector_start,
    input  logic             queue_full,
    output logic             push,
    output logic [JOB_W-1:0] push_data
);

    logic [8:0] offset_reg;
    logic [8:0] offset_next;
    logic [4:0] flags_reg;
    logic [4:0] flags_next;
    logic       marker_reg;
    logic       marker_next;

    bspp_pkg::entry_t [MAX_PARTITIONS-1:0] entry_reg;
    bspp_pkg::entry_t [MAX_PARTITIONS-1:0] entry_next;

    logic       accept;
    logic [8:0] off;
    logic [8:0] rel;
    logic [8:0] name_rel;
    logic       in_table;
    logic       sig;
    logic [2:0] fs;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign off      = sector_start ? 9'd0 : offset_reg;
    assign rel      = off - bspp_pkg::TABLE_BASE;
    assign in_table = (off >= bspp_pkg::TABLE_BASE) && (off < bspp_pkg::TABLE_END);

    always_comb
    begin
        offset_next = offset_reg;
        flags_next  = flags_reg;
        marker_next = marker_reg;
        entry_next  = entry_reg;
        name_rel    = '0;
        if (accept)
        begin
            offset_next = off + 9'd1;
            if (off == 9'd0)
            begin
                flags_next  = '1;
                marker_next = 1'b0;
            end
            for (int k = 0; k < bspp_pkg::NAME_COUNT; k++)
            begin
                name_rel = off - bspp_pkg::NAME_BASE[k];
                if ((off >= bspp_pkg::NAME_BASE[k]) && (name_rel < 9'(bspp_pkg::NAME_LEN))
                    && (data_byte != bspp_pkg::name_char(k, name_rel[2:0])))
                begin
                    flags_next[k] = 1'b0;
                end
            end
            if (in_table)
            begin
                for (int j = 0; j < MAX_PARTITIONS; j++)
                begin
                    if (rel[5:4] == 2'(j))
                    begin
                        if (rel[3:0] == bspp_pkg::FIELD_TYPE)
                        begin
                            entry_next[j].ptype = data_byte;
                        end
                        for (int l = 0; l < 4; l++)
                        begin
                            if ((rel[3:2] == bspp_pkg::LANE_START) && (rel[1:0] == 2'(l)))
                            begin
                                entry_next[j].start[8*l +: 8] = data_byte;
                            end
                            if ((rel[3:2] == bspp_pkg::LANE_COUNT) && (rel[1:0] == 2'(l)))
                            begin
                                entry_next[j].count[8*l +: 8] = data_byte;
                            end
                        end
                    end
                end
            end
            if (off == bspp_pkg::SIG_FIRST)
            begin
                marker_next = (data_byte == bspp_pkg::MARK_FIRST);
            end
        end
    end

    always_comb
    begin
        fs = bspp_pkg::FS_UNKNOWN;
        for (int k = bspp_pkg::NAME_COUNT - 1; k >= 0; k--)
        begin
            if (flags_next[k])
            begin
                fs = 3'(k + 1);
            end
        end
    end

    assign sig       = marker_reg && (data_byte == bspp_pkg::MARK_SECOND);
    assign push      = accept && (off == bspp_pkg::SIG_SECOND);
    assign push_data = {entry_reg, sig, fs};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            flags_reg  <= '1;
            marker_reg <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            flags_reg  <= flags_next;
            marker_reg <= marker_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* hdl/bspp_queue.sv */
// ----------------------------------------------------------------------------
// bspp_queue: sector job queue
// Short first-in first-out store between the byte front and the result back.
// ----------------------------------------------------------------------------
module bspp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bspp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/bspp_back.sv */
// ----------------------------------------------------------------------------
// bspp_back: result sequencer
// Walks the entries of the head sector job, emits one result per present
// entry, then the sector summary, through a registered output stage.
// ----------------------------------------------------------------------------
module bspp_back #(
    parameter int MAX_PARTITIONS = bspp_pkg::MAX_PARTITIONS_DEFAULT,
    parameter int JOB_W          = 4 + MAX_PARTITIONS * bspp_pkg::ENTRY_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [JOB_W-1:0]   head_data,
    input  logic               queue_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output bspp_pkg::result_t  result,
    output logic [$clog2(MAX_PARTITIONS+1)-1:0] scan
);

    localparam int SCAN_W = $clog2(MAX_PARTITIONS + 1);

    logic [SCAN_W-1:0]  scan_reg;
    logic [2:0]         dense_reg;
    logic               gpt_reg;
    logic               valid_reg;
    logic               valid_next;
    bspp_pkg::result_t  result_reg;
    bspp_pkg::result_t  result_next;

    logic               slot_free;
    logic               step;
    logic               at_summary;
    logic               head_sig;
    logic [2:0]         head_fs;
    bspp_pkg::entry_t   sel;
    logic               present;

    assign slot_free  = !valid_reg || out_ready;
    assign step       = slot_free && !queue_empty;
    assign at_summary = (scan_reg == SCAN_W'(MAX_PARTITIONS));
    assign head_fs    = head_data[2:0];
    assign head_sig   = head_data[3];
    assign pop        = step && at_summary;

    always_comb
    begin
        sel = '0;
        for (int j = 0; j < MAX_PARTITIONS; j++)
        begin
            if (scan_reg == SCAN_W'(j))
            begin
                sel = head_data[4 + j*bspp_pkg::ENTRY_W +: bspp_pkg::ENTRY_W];
            end
        end
    end

    assign present = head_sig && (sel.ptype != '0) && (sel.count != '0);

    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        if (step && (at_summary || present))
        begin
            valid_next = 1'b1;
        end
    end

    always_comb
    begin
        result_next = '0;
        if (at_summary)
        begin
            result_next.result_kind     = bspp_pkg::KIND_SUMMARY;
            result_next.signature_ok    = head_sig;
            result_next.fs_kind         = head_fs;
            result_next.protective_gpt  = gpt_reg;
            result_next.partition_count = dense_reg;
            result_next.last            = 1'b1;
        end
        else
        begin
            result_next.result_kind  = bspp_pkg::KIND_ENTRY;
            result_next.entry_index  = dense_reg[1:0];
            result_next.part_type    = sel.ptype;
            result_next.start_lba    = sel.start;
            result_next.sector_count = sel.count;
            result_next.signature_ok = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= '0;
            dense_reg <= '0;
            gpt_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (step)
            begin
                if (at_summary)
                begin
                    scan_reg  <= '0;
                    dense_reg <= '0;
                    gpt_reg   <= 1'b0;
                end
                else
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (present)
                    begin
                        dense_reg <= dense_reg + 3'd1;
                        if (sel.ptype == bspp_pkg::GPT_TYPE)
                        begin
                            gpt_reg <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;
    assign scan      = scan_reg;

endmodule

/* hdl/boot_sector_partition_parser_core.sv */
// ----------------------------------------------------------------------------
// boot_sector_partition_parser_core: boot sector partition table parser
// Parses a 512-byte sector streamed one byte per transfer and reports the
// present partition entries and a sector summary.
// ----------------------------------------------------------------------------
// The block takes one sector byte per cycle, in order from offset 0; a high
// s_tuser marks offset 0 and restarts the count. After byte 511 the sector's
// entries, signature and filesystem kind move into a two-deep job queue, and
// the back end takes one step per table entry and one for the summary on
// each job, emitting one result per present entry and then the summary with
// m_tlast high. Input stalls only while the job queue is full, so a
// sustained stream runs at one byte per cycle.
module boot_sector_partition_parser_core #(
    parameter int MAX_PARTITIONS = bspp_pkg::MAX_PARTITIONS_DEFAULT,
    parameter int QUEUE_DEPTH    = bspp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] sector_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // entry_index, part_type, start_lba, sector_count,
                                   // signature_ok, fs_kind, protective_gpt,
                                   // partition_count, zero pad
    output logic        m_tuser,   // [0] result_kind
    output logic        m_tlast
);

    localparam int JOB_W  = 4 + MAX_PARTITIONS * bspp_pkg::ENTRY_W;
    localparam int SCAN_W = $clog2(MAX_PARTITIONS + 1);

    logic               push;
    logic [JOB_W-1:0]   push_data;
    logic               pop;
    logic [JOB_W-1:0]   head_data;
    logic               queue_empty;
    logic               queue_full;
    bspp_pkg::result_t  result;
    logic [SCAN_W-1:0]  scan;

    bspp_front #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .JOB_W          (JOB_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .data_byte    (s_tdata),
        .sector_start (s_tuser),
        .queue_full   (queue_full),
        .push         (push),
        .push_data    (push_data)
    );

    bspp_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    bspp_back #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .JOB_W          (JOB_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_data   (head_data),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .result      (result),
        .scan        (scan)
    );

    assign m_tdata = {6'd0,
                      result.partition_count,
                      result.protective_gpt,
                      result.fs_kind,
                      result.signature_ok,
                      result.sector_count,
                      result.start_lba,
                      result.part_type,
                      result.entry_index};
    assign m_tuser = result.result_kind;
    assign m_tlast = result.last;

    a_entry_needs_signature: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (result.result_kind == bspp_pkg::KIND_ENTRY)
        |-> result.signature_ok && !result.last)
        else $error("entry result without signature or with last set");

    a_summary_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (result.result_kind == bspp_pkg::KIND_SUMMARY)
        |-> result.last && (result.partition_count <= 3'(MAX_PARTITIONS)))
        else $error("summary without last or with too many partitions");

    a_no_sig_no_parts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (result.result_kind == bspp_pkg::KIND_SUMMARY) && !result.signature_ok
        |-> (result.partition_count == 3'd0) && !result.protective_gpt)
        else $error("partitions reported without signature");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan <= SCAN_W'(MAX_PARTITIONS))
        else $error("entry scan past table end");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("job pushed into full queue");

endmodule
